// ----- rtl/shpq_pkg.sv -----
// Shared types, codes and defaults of the subtitle priority holdback queue.
package shpq_pkg;

   // Fixed field widths
   localparam int HANDLE_BITS = 32;
   localparam int KIND_BITS   = 2;
   localparam int OP_BITS     = 2;
   localparam int CFG_BITS    = 14;

   // Default storage sizes
   localparam int MAIN_DEPTH_DEFAULT = 8192;
   localparam int SUB_DEPTH_DEFAULT  = 256;

   // Register reset values
   localparam logic [CFG_BITS-1:0] VIDEO_THRESHOLD_RESET = 14'd48;
   localparam logic [CFG_BITS-1:0] HOLD_LIMIT_RESET      = 14'd8192;

   // Register indexes
   localparam logic CSR_VIDEO_THRESHOLD = 1'b0;
   localparam logic CSR_HOLD_LIMIT      = 1'b1;

   // Operation codes
   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_GET   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

   // Packet kinds
   localparam logic [KIND_BITS-1:0] KIND_VIDEO    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_AUDIO    = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DROP     = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_SUBTITLE = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]     operation;
      logic [KIND_BITS-1:0]   packet_kind;
      logic [HANDLE_BITS-1:0] packet_handle;
      logic                   flushing;
   } req_type;

   typedef struct packed {
      logic                   has_packet;
      logic [HANDLE_BITS-1:0] out_handle;
      logic [KIND_BITS-1:0]   out_kind;
      logic                   overflow;
   } rsp_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic take;
      logic exec;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_blocked;
   } status_type;

endpackage

// ----- rtl/subtitle_priority_holdback_queue.sv -----
// Top level of the subtitle priority holdback queue.
// For each request, the transfer in starts a read of both FIFO heads from
// their RAMs, and the next cycle applies the add, get or clear and loads the
// result register; a new request is not taken until the apply step of the
// last one is done, as the head read is registered. A request is taken while
// the previous result still waits as long as that result leaves in the same
// cycle. Every request gives exactly one result. Subtitle adds go to a
// SUB_DEPTH-entry priority FIFO; video, audio and drop markers to a
// MAIN_DEPTH-entry main FIFO. A get returns a waiting subtitle first,
// otherwise the main head only on flushing, once video_threshold video
// entries are queued, or once occupancy reaches hold_limit. Both FIFOs are
// tracked by counts, so reset and clear take effect at once, with no
// clearing pass. Write csr_* only while no request is in progress.
module subtitle_priority_holdback_queue #(
   parameter int MAIN_DEPTH = shpq_pkg::MAIN_DEPTH_DEFAULT,
   parameter int SUB_DEPTH  = shpq_pkg::SUB_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  shpq_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output shpq_pkg::rsp_type             rsp_payload,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [shpq_pkg::CFG_BITS-1:0] csr_wr_data
);
   import shpq_pkg::*;

   cmd_type    cmd;
   status_type status;

   shpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   shpq_dp #(
      .MAIN_DEPTH (MAIN_DEPTH),
      .SUB_DEPTH  (SUB_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- rtl/shpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module shpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/shpq_ctrl.sv -----
// Controller state machine: accept one request, then apply it.
module shpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  shpq_pkg::status_type status,
   output shpq_pkg::cmd_type    cmd
);
   import shpq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      can_take;

   // Accept only when idle and the result register is free or draining
   assign can_take = (state_ff == ST_IDLE) && !status.out_blocked;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (can_take && req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !can_take;
            cmd.take  = can_take && req_valid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Every apply step follows exactly one transfer in
   a_exec_after_take: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> $past(cmd.take))
      else $error("apply step without a preceding transfer");

   a_no_back_to_back_take: assert property (@(posedge clock) disable iff (reset)
      cmd.take |=> !cmd.take)
      else $error("transfer accepted during apply step");

endmodule

// ----- rtl/shpq_dp.sv -----
// Datapath: FIFO storage, pointers, counts, release decision and result register.
module shpq_dp #(
   parameter int MAIN_DEPTH = shpq_pkg::MAIN_DEPTH_DEFAULT,
   parameter int SUB_DEPTH  = shpq_pkg::SUB_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  shpq_pkg::req_type                 req_payload,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [shpq_pkg::CFG_BITS-1:0]     csr_wr_data,
   input  shpq_pkg::cmd_type                 cmd,
   output shpq_pkg::status_type              status,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output shpq_pkg::rsp_type                 rsp_payload
);
   import shpq_pkg::*;

   localparam int MAIN_AW = $clog2(MAIN_DEPTH);
   localparam int MAIN_CW = $clog2(MAIN_DEPTH + 1);
   localparam int MAIN_SW = MAIN_AW + 1;
   localparam int SUB_AW  = $clog2(SUB_DEPTH);
   localparam int SUB_CW  = $clog2(SUB_DEPTH + 1);
   localparam int SUB_SW  = SUB_AW + 1;
   localparam int CMP_W   = (MAIN_CW > CFG_BITS) ? MAIN_CW : CFG_BITS;
   localparam int MAIN_W  = HANDLE_BITS + KIND_BITS;

   req_type               req_ff;
   logic [MAIN_AW-1:0]    main_rd_ptr_ff, main_rd_ptr_in;
   logic [MAIN_CW-1:0]    main_count_ff, main_count_in;
   logic [MAIN_CW-1:0]    video_count_ff, video_count_in;
   logic [SUB_AW-1:0]     sub_rd_ptr_ff, sub_rd_ptr_in;
   logic [SUB_CW-1:0]     sub_count_ff, sub_count_in;
   logic [CFG_BITS-1:0]   video_threshold_ff;
   logic [CFG_BITS-1:0]   hold_limit_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff, rsp_in;

   logic [MAIN_SW-1:0]    main_wr_sum;
   logic [MAIN_AW-1:0]    main_wr_addr;
   logic [SUB_SW-1:0]     sub_wr_sum;
   logic [SUB_AW-1:0]     sub_wr_addr;
   logic                  main_wr_en;
   logic                  sub_wr_en;
   logic [MAIN_W-1:0]     main_rd_data;
   logic [HANDLE_BITS-1:0] sub_rd_data;
   logic                  main_full;
   logic                  sub_full;
   logic                  main_release;
   logic [KIND_BITS-1:0]  main_head_kind;

   // Tail addresses wrap at the depth
   assign main_wr_sum  = {1'b0, main_rd_ptr_ff} + MAIN_SW'(main_count_ff);
   assign main_wr_addr = (main_wr_sum >= MAIN_SW'(MAIN_DEPTH))
                         ? MAIN_AW'(main_wr_sum - MAIN_SW'(MAIN_DEPTH))
                         : MAIN_AW'(main_wr_sum);
   assign sub_wr_sum   = {1'b0, sub_rd_ptr_ff} + SUB_SW'(sub_count_ff);
   assign sub_wr_addr  = (sub_wr_sum >= SUB_SW'(SUB_DEPTH))
                         ? SUB_AW'(sub_wr_sum - SUB_SW'(SUB_DEPTH))
                         : SUB_AW'(sub_wr_sum);

   assign main_full = (main_count_ff == MAIN_CW'(MAIN_DEPTH));
   assign sub_full  = (sub_count_ff == SUB_CW'(SUB_DEPTH));

   // Release the main head on flush, enough video, or occupancy at the limit
   assign main_release = (main_count_ff != '0) &&
                         (req_ff.flushing ||
                          (CMP_W'(video_count_ff) >= CMP_W'(video_threshold_ff)) ||
                          (CMP_W'(main_count_ff) >= CMP_W'(hold_limit_ff)));

   assign main_head_kind = main_rd_data[KIND_BITS-1:0];

   assign main_wr_en = cmd.exec && (req_ff.operation == OP_ADD) &&
                       (req_ff.packet_kind != KIND_SUBTITLE) && !main_full;
   assign sub_wr_en  = cmd.exec && (req_ff.operation == OP_ADD) &&
                       (req_ff.packet_kind == KIND_SUBTITLE) && !sub_full;

   // Head reads are started at the transfer in, data is ready on apply
   shpq_ram #(
      .WIDTH (MAIN_W),
      .DEPTH (MAIN_DEPTH)
   ) u_main_ram (
      .clock   (clock),
      .wr_en   (main_wr_en),
      .wr_addr (main_wr_addr),
      .wr_data ({req_ff.packet_handle, req_ff.packet_kind}),
      .rd_en   (cmd.take),
      .rd_addr (main_rd_ptr_ff),
      .rd_data (main_rd_data)
   );

   shpq_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (SUB_DEPTH)
   ) u_sub_ram (
      .clock   (clock),
      .wr_en   (sub_wr_en),
      .wr_addr (sub_wr_addr),
      .wr_data (req_ff.packet_handle),
      .rd_en   (cmd.take),
      .rd_addr (sub_rd_ptr_ff),
      .rd_data (sub_rd_data)
   );

   // Apply the latched request
   always_comb begin
      main_rd_ptr_in = main_rd_ptr_ff;
      main_count_in  = main_count_ff;
      video_count_in = video_count_ff;
      sub_rd_ptr_in  = sub_rd_ptr_ff;
      sub_count_in   = sub_count_ff;
      rsp_in         = '0;
      case (req_ff.operation)
         OP_ADD: begin
            if (req_ff.packet_kind == KIND_SUBTITLE) begin
               if (sub_full) begin
                  rsp_in.overflow = 1'b1;
               end else begin
                  sub_count_in = sub_count_ff + 1'b1;
               end
            end else if (main_full) begin
               rsp_in.overflow = 1'b1;
            end else begin
               main_count_in = main_count_ff + 1'b1;
               if (req_ff.packet_kind == KIND_VIDEO) begin
                  video_count_in = video_count_ff + 1'b1;
               end
            end
         end
         OP_GET: begin
            if (sub_count_ff != '0) begin
               rsp_in.has_packet = 1'b1;
               rsp_in.out_handle = sub_rd_data;
               rsp_in.out_kind   = KIND_SUBTITLE;
               sub_rd_ptr_in = (sub_rd_ptr_ff == SUB_AW'(SUB_DEPTH - 1))
                               ? '0 : sub_rd_ptr_ff + 1'b1;
               sub_count_in  = sub_count_ff - 1'b1;
            end else if (main_release) begin
               rsp_in.has_packet = 1'b1;
               rsp_in.out_handle = main_rd_data[MAIN_W-1:KIND_BITS];
               rsp_in.out_kind   = main_head_kind;
               if ((main_head_kind == KIND_VIDEO) && (video_count_ff != '0)) begin
                  video_count_in = video_count_ff - 1'b1;
               end
               main_rd_ptr_in = (main_rd_ptr_ff == MAIN_AW'(MAIN_DEPTH - 1))
                                ? '0 : main_rd_ptr_ff + 1'b1;
               main_count_in  = main_count_ff - 1'b1;
            end
         end
         OP_CLEAR: begin
            main_rd_ptr_in = '0;
            main_count_in  = '0;
            video_count_in = '0;
            sub_rd_ptr_in  = '0;
            sub_count_in   = '0;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   // Hold the request for the apply step
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         req_ff <= req_payload;
      end
   end

   // Advance FIFO state
   always_ff @(posedge clock) begin
      if (reset) begin
         main_rd_ptr_ff <= '0;
         main_count_ff  <= '0;
         video_count_ff <= '0;
         sub_rd_ptr_ff  <= '0;
         sub_count_ff   <= '0;
      end else if (cmd.exec) begin
         main_rd_ptr_ff <= main_rd_ptr_in;
         main_count_ff  <= main_count_in;
         video_count_ff <= video_count_in;
         sub_rd_ptr_ff  <= sub_rd_ptr_in;
         sub_count_ff   <= sub_count_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         video_threshold_ff <= VIDEO_THRESHOLD_RESET;
         hold_limit_ff      <= HOLD_LIMIT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_VIDEO_THRESHOLD: video_threshold_ff <= csr_wr_data;
            CSR_HOLD_LIMIT:      hold_limit_ff      <= csr_wr_data;
            default:             hold_limit_ff      <= hold_limit_ff;
         endcase
      end
   end

   // Result register: load on apply, drop on transfer out
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload        = rsp_ff;
   assign status.out_blocked = rsp_valid_ff && rsp_stall;

   a_video_within_main: assert property (@(posedge clock) disable iff (reset)
      video_count_ff <= main_count_ff)
      else $error("video count exceeds main occupancy");

   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      (main_count_ff <= MAIN_CW'(MAIN_DEPTH)) && (sub_count_ff <= SUB_CW'(SUB_DEPTH)))
      else $error("FIFO count beyond depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (req_ff.operation == OP_CLEAR)) |=>
      ((main_count_ff == '0) && (sub_count_ff == '0) && (video_count_ff == '0)))
      else $error("clear left entries queued");

endmodule
